>>> sv/acpi_table_header_checker_macros.svh
// ----------------------------------------------------------------------------
// ACPI table checker assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ACPI_TABLE_HEADER_CHECKER_MACROS_SVH
`define ACPI_TABLE_HEADER_CHECKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define ACPI_THC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ACPI_THC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ACPI_THC_ASSERT_NOW(label, clk, rst, ante, cons)
`define ACPI_THC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/acpi_thc_pkg.sv
// ----------------------------------------------------------------------------
// ACPI table checker package
// Types, codes and constants shared by the checker modules.
// ----------------------------------------------------------------------------
package acpi_thc_pkg;

   localparam int unsigned DATA_W  = 8;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned CSR_W   = 32;

   localparam logic [COUNT_W-1:0] ROOT_LEN   = 32'd36;
   localparam logic [COUNT_W-1:0] SHORT_LEN  = 32'd20;
   localparam logic [COUNT_W-1:0] REV_OFFSET = 32'd15;
   localparam logic [COUNT_W-1:0] HDR_MIN    = 32'd8;

   localparam logic        RESET_TABLE_MODE        = 1'b0;
   localparam logic [31:0] RESET_HEADER_SIGNATURE  = 32'd1346584902;
   localparam logic [7:0]  RESET_REQUIRED_REVISION = 8'd2;

   // "RSD PTR ", offset 0 first
   localparam logic [7:0] ROOT_SIG [8] = '{8'h52, 8'h53, 8'h44, 8'h20,
                                           8'h50, 8'h54, 8'h52, 8'h20};

   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_SIGNATURE,
      STATUS_REVISION,
      STATUS_SHORT_SUM,
      STATUS_FULL_SUM,
      STATUS_LEN_SMALL
   } status_type;

   typedef enum logic [1:0] {
      CSR_TABLE_MODE,
      CSR_HEADER_SIGNATURE,
      CSR_REQUIRED_REVISION
   } csr_index_type;

   typedef struct packed {
      logic        table_mode;
      logic [31:0] header_signature;
      logic [7:0]  required_revision;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      status_type         status;
      logic [COUNT_W-1:0] bytes_checked;
   } rsp_type;

endpackage

>>> sv/acpi_table_header_checker.sv
// ----------------------------------------------------------------------------
// ACPI table header checker
// Checks a firmware table byte stream and gives at most one verdict per table.
// ----------------------------------------------------------------------------
// The block takes one table byte per clock for as long as verdicts are taken;
// each byte is checked by combinational logic that updates the byte count,
// the 8-bit running sum and the sticky check flags. The verdict for a table
// appears on the response side in the cycle after its last byte is accepted,
// unless an earlier verdict is still waiting there. A two-entry output queue
// lets bytes keep flowing while a verdict waits; req_ready drops only when both
// queue entries are occupied. Configuration is write-only and takes effect on
// the next byte.
module acpi_table_header_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [acpi_thc_pkg::DATA_W-1:0]    req_data_byte,
   input  logic                               req_first_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic [acpi_thc_pkg::COUNT_W-1:0]   rsp_bytes_checked,
   input  logic                               csr_write_enable,
   input  logic [1:0]                         csr_index,
   input  logic [acpi_thc_pkg::CSR_W-1:0]     csr_write_data
);

`include "acpi_table_header_checker_macros.svh"

   acpi_thc_pkg::cfg_type cfg;
   acpi_thc_pkg::rsp_type result;
   logic                  accept;

   assign accept = req_valid && req_ready;

   acpi_thc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   acpi_thc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .first_byte (req_first_byte),
      .cfg        (cfg),
      .result     (result)
   );

   acpi_thc_outq u_outq (
      .clock             (clock),
      .reset             (reset),
      .push              (result),
      .space             (req_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_bytes_checked (rsp_bytes_checked)
   );

   // skid slot fills only behind an occupied head
   `ACPI_THC_ASSERT_NOW(a_stall_has_head, clock, reset, !req_ready, rsp_valid)
   // a stalled, full queue stays full
   `ACPI_THC_ASSERT_NEXT(a_full_holds, clock, reset, !req_ready && !rsp_ready, !req_ready)
   // every table is at least a minimal header long
   `ACPI_THC_ASSERT_NOW(a_min_count, clock, reset, rsp_valid,
      rsp_bytes_checked >= acpi_thc_pkg::HDR_MIN)
   `ACPI_THC_ASSERT_NOW(a_status_code, clock, reset, rsp_valid,
      rsp_status <= 3'(acpi_thc_pkg::STATUS_LEN_SMALL))

endmodule

>>> sv/acpi_thc_csr.sv
// ----------------------------------------------------------------------------
// ACPI table checker configuration registers
// Write-only register bank for mode, header signature and root revision.
// ----------------------------------------------------------------------------
module acpi_thc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [1:0]                       csr_index,
   input  logic [acpi_thc_pkg::CSR_W-1:0]   csr_write_data,
   output acpi_thc_pkg::cfg_type            cfg
);

   acpi_thc_pkg::cfg_type cfg_ff;
   acpi_thc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            acpi_thc_pkg::CSR_TABLE_MODE:
               cfg_in.table_mode = csr_write_data[0];
            acpi_thc_pkg::CSR_HEADER_SIGNATURE:
               cfg_in.header_signature = csr_write_data[31:0];
            acpi_thc_pkg::CSR_REQUIRED_REVISION:
               cfg_in.required_revision = csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.table_mode        <= acpi_thc_pkg::RESET_TABLE_MODE;
         cfg_ff.header_signature  <= acpi_thc_pkg::RESET_HEADER_SIGNATURE;
         cfg_ff.required_revision <= acpi_thc_pkg::RESET_REQUIRED_REVISION;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/acpi_thc_core.sv
// ----------------------------------------------------------------------------
// ACPI table checker core
// Per-byte update of count, running sum and sticky checks; forms the verdict.
// ----------------------------------------------------------------------------
module acpi_thc_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [acpi_thc_pkg::DATA_W-1:0]   data_byte,
   input  logic                              first_byte,
   input  acpi_thc_pkg::cfg_type             cfg,
   output acpi_thc_pkg::rsp_type             result
);

   localparam int unsigned CW = acpi_thc_pkg::COUNT_W;

   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    sum_ff, sum_in;
   logic          sig_ok_ff, sig_ok_in;
   logic          rev_ok_ff, rev_ok_in;
   logic          short_ok_ff, short_ok_in;
   logic [CW-1:0] length_ff, length_in;
   logic          idle_ff, idle_in;

   always_comb begin
      logic [CW-1:0] pos;
      logic [7:0]    sum_cur;
      logic          sig_cur, rev_cur, short_cur;
      logic [CW-1:0] len_cur;
      logic          active;
      logic          pos_lt8, pos_lt4;
      logic [7:0]    exp_byte;
      logic          zero_before;
      logic          done, too_small;

      // first byte restarts everything, in progress or idle
      pos       = first_byte ? '0 : count_ff;
      sum_cur   = first_byte ? '0 : sum_ff;
      sig_cur   = first_byte | sig_ok_ff;
      rev_cur   = first_byte | rev_ok_ff;
      short_cur = first_byte | short_ok_ff;
      len_cur   = first_byte ? '0 : length_ff;
      active    = accept && (first_byte || !idle_ff);

      pos_lt8 = (pos[CW-1:3] == '0);
      pos_lt4 = (pos[CW-1:2] == '0);

      sum_cur  = sum_cur + data_byte;
      count_in = (pos == '1) ? pos : pos + CW'(1);

      if (pos_lt8 && pos[2]) begin
         len_cur[{pos[1:0], 3'b000} +: 8] = data_byte;
      end

      exp_byte = cfg.header_signature[{pos[1:0], 3'b000} +: 8];
      case (pos[1:0])
         2'd1:    zero_before = (cfg.header_signature[7:0] == 8'h00);
         2'd2:    zero_before = (cfg.header_signature[7:0] == 8'h00) ||
                                (cfg.header_signature[15:8] == 8'h00);
         2'd3:    zero_before = (cfg.header_signature[7:0] == 8'h00) ||
                                (cfg.header_signature[15:8] == 8'h00) ||
                                (cfg.header_signature[23:16] == 8'h00);
         default: zero_before = 1'b0;
      endcase

      done      = 1'b0;
      too_small = 1'b0;
      if (!cfg.table_mode) begin
         if (pos_lt8 && data_byte != acpi_thc_pkg::ROOT_SIG[pos[2:0]]) begin
            sig_cur = 1'b0;
         end
         if (pos == acpi_thc_pkg::REV_OFFSET && data_byte != cfg.required_revision) begin
            rev_cur = 1'b0;
         end
         if (count_in == acpi_thc_pkg::SHORT_LEN && sum_cur != 8'h00) begin
            short_cur = 1'b0;
         end
         done = (count_in >= acpi_thc_pkg::ROOT_LEN);
      end else begin
         if (pos_lt4 && !(zero_before || data_byte == exp_byte)) begin
            sig_cur = 1'b0;
         end
         if (count_in >= acpi_thc_pkg::HDR_MIN) begin
            too_small = (len_cur < acpi_thc_pkg::HDR_MIN);
            done      = too_small || (count_in >= len_cur);
         end
      end

      result.valid         = active && done;
      result.bytes_checked = count_in;
      if (!sig_cur) begin
         result.status = acpi_thc_pkg::STATUS_SIGNATURE;
      end else if (!rev_cur) begin
         result.status = acpi_thc_pkg::STATUS_REVISION;
      end else if (!short_cur) begin
         result.status = acpi_thc_pkg::STATUS_SHORT_SUM;
      end else if (too_small) begin
         result.status = acpi_thc_pkg::STATUS_LEN_SMALL;
      end else if (sum_cur != 8'h00) begin
         result.status = acpi_thc_pkg::STATUS_FULL_SUM;
      end else begin
         result.status = acpi_thc_pkg::STATUS_OK;
      end

      // hold state on idle bytes and cycles with no request
      if (active) begin
         sum_in      = sum_cur;
         sig_ok_in   = sig_cur;
         rev_ok_in   = rev_cur;
         short_ok_in = short_cur;
         length_in   = len_cur;
         idle_in     = done;
      end else begin
         count_in    = count_ff;
         sum_in      = sum_ff;
         sig_ok_in   = sig_ok_ff;
         rev_ok_in   = rev_ok_ff;
         short_ok_in = short_ok_ff;
         length_in   = length_ff;
         idle_in     = idle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         sum_ff      <= '0;
         sig_ok_ff   <= 1'b1;
         rev_ok_ff   <= 1'b1;
         short_ok_ff <= 1'b1;
         length_ff   <= '0;
         idle_ff     <= 1'b1;
      end else begin
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         sig_ok_ff   <= sig_ok_in;
         rev_ok_ff   <= rev_ok_in;
         short_ok_ff <= short_ok_in;
         length_ff   <= length_in;
         idle_ff     <= idle_in;
      end
   end

endmodule

>>> sv/acpi_thc_outq.sv
// ----------------------------------------------------------------------------
// ACPI table checker output queue
// Two-entry result register with skid slot; decouples request and response.
// ----------------------------------------------------------------------------
module acpi_thc_outq (
   input  logic                               clock,
   input  logic                               reset,
   input  acpi_thc_pkg::rsp_type              push,
   output logic                               space,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic [acpi_thc_pkg::COUNT_W-1:0]   rsp_bytes_checked
);

   acpi_thc_pkg::rsp_type head_ff, head_in;
   acpi_thc_pkg::rsp_type skid_ff, skid_in;

   always_comb begin
      head_in = head_ff;
      skid_in = skid_ff;
      if (!head_ff.valid || rsp_ready) begin
         // advance: skid first, else the new verdict
         if (skid_ff.valid) begin
            head_in       = skid_ff;
            skid_in.valid = 1'b0;
         end else begin
            head_in = push;
         end
      end else if (push.valid) begin
         skid_in = push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
         skid_ff.valid <= 1'b0;
      end else begin
         head_ff.valid <= head_in.valid;
         skid_ff.valid <= skid_in.valid;
      end
      head_ff.status        <= head_in.status;
      head_ff.bytes_checked <= head_in.bytes_checked;
      skid_ff.status        <= skid_in.status;
      skid_ff.bytes_checked <= skid_in.bytes_checked;
   end

   assign space             = !skid_ff.valid;
   assign rsp_valid         = head_ff.valid;
   assign rsp_status        = head_ff.status;
   assign rsp_bytes_checked = head_ff.bytes_checked;

endmodule

>>> tb/tb_acpi_table_header_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ACPI table header checker testbench
// Streams root-pointer and description-header tables through the checker,
// with random sender gaps and receiver stalls, and compares every verdict
// against a cycle-free model of the byte checks held in a scoreboard class.
// ----------------------------------------------------------------------------
module tb_acpi_table_header_checker;

   localparam int unsigned ITEM_TARGET    = 800;
   localparam int unsigned VERDICT_TARGET = 60;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned STALL_LIMIT    = 2000;

   typedef logic [7:0] byte_list_type[$];

   class verdict_board_type;
      logic        mode;
      logic [31:0] sig;
      logic [7:0]  rev;

      logic [31:0] byte_tally;
      logic [7:0]  byte_sum;
      logic [31:0] table_len;
      bit          sig_ok;
      bit          rev_ok;
      bit          short_ok;
      bit          awaiting_first;

      acpi_thc_pkg::status_type status_q[$];
      logic [31:0] tally_q[$];
      int          errors;
      int          verdicts;
      int          status_seen[6];

      function new();
         mode = acpi_thc_pkg::RESET_TABLE_MODE;
         sig  = acpi_thc_pkg::RESET_HEADER_SIGNATURE;
         rev  = acpi_thc_pkg::RESET_REQUIRED_REVISION;
         start_table();
         awaiting_first = 1'b1;
      endfunction

      function void start_table();
         byte_tally     = '0;
         byte_sum       = '0;
         table_len      = '0;
         sig_ok         = 1'b1;
         rev_ok         = 1'b1;
         short_ok       = 1'b1;
         awaiting_first = 1'b0;
      endfunction

      // Header signature compare stops after the first zero byte.
      function bit sig_byte_matches(int unsigned pos, logic [7:0] b);
         for (int i = 0; i < pos; i++)
            if (sig[8*i +: 8] == 8'h00) return 1'b1;
         return b == sig[8*pos +: 8];
      endfunction

      // Returns 1 when the request takes part in a table.
      function bit note_request(logic [7:0] b, logic first);
         int unsigned pos;
         bit          done;
         bit          too_small;
         acpi_thc_pkg::status_type st;
         done      = 1'b0;
         too_small = 1'b0;
         if (first) start_table();
         if (awaiting_first) return 1'b0;

         pos = byte_tally;
         byte_sum += b;
         if (byte_tally != '1) byte_tally++;
         if (pos >= 4 && pos < 8) table_len[8*(pos-4) +: 8] = b;

         if (!mode) begin
            if (pos < 8 && b != acpi_thc_pkg::ROOT_SIG[pos]) sig_ok = 1'b0;
            if (pos == acpi_thc_pkg::REV_OFFSET && b != rev) rev_ok = 1'b0;
            if (byte_tally == acpi_thc_pkg::SHORT_LEN && byte_sum != 8'h00)
               short_ok = 1'b0;
            if (byte_tally >= acpi_thc_pkg::ROOT_LEN) done = 1'b1;
         end else begin
            if (pos < 4 && !sig_byte_matches(pos, b)) sig_ok = 1'b0;
            if (byte_tally >= acpi_thc_pkg::HDR_MIN) begin
               if (table_len < acpi_thc_pkg::HDR_MIN) begin
                  too_small = 1'b1;
                  done      = 1'b1;
               end else if (byte_tally >= table_len) begin
                  done = 1'b1;
               end
            end
         end

         if (done) begin
            if (!sig_ok)                st = acpi_thc_pkg::STATUS_SIGNATURE;
            else if (!rev_ok)           st = acpi_thc_pkg::STATUS_REVISION;
            else if (!short_ok)         st = acpi_thc_pkg::STATUS_SHORT_SUM;
            else if (too_small)         st = acpi_thc_pkg::STATUS_LEN_SMALL;
            else if (byte_sum != 8'h00) st = acpi_thc_pkg::STATUS_FULL_SUM;
            else                        st = acpi_thc_pkg::STATUS_OK;
            status_q.push_back(st);
            tally_q.push_back(byte_tally);
            awaiting_first = 1'b1;
         end
         return 1'b1;
      endfunction

      function void check_verdict(logic [2:0] got_status, logic [31:0] got_tally);
         acpi_thc_pkg::status_type want_status;
         logic [31:0] want_tally;
         if (status_q.size() == 0) begin
            $error("verdict with none pending: status %0d, bytes_checked %0d",
                   got_status, got_tally);
            errors++;
         end else begin
            want_status = status_q.pop_front();
            want_tally  = tally_q.pop_front();
            verdicts++;
            status_seen[int'(want_status)]++;
            if (got_status !== want_status) begin
               $error("status: expected %0d, got %0d", want_status, got_status);
               errors++;
            end
            if (got_tally !== want_tally) begin
               $error("bytes_checked: expected %0d, got %0d", want_tally, got_tally);
               errors++;
            end
         end
      endfunction

      function int pending();
         return status_q.size();
      endfunction
   endclass

   logic                               clock;
   logic                               reset            = 1'b1;
   logic                               req_valid        = 1'b0;
   logic                               req_ready;
   logic [acpi_thc_pkg::DATA_W-1:0]    req_data_byte    = '0;
   logic                               req_first_byte   = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_ready        = 1'b0;
   logic [2:0]                         rsp_status;
   logic [acpi_thc_pkg::COUNT_W-1:0]   rsp_bytes_checked;
   logic                               csr_write_enable = 1'b0;
   logic [1:0]                         csr_index        = '0;
   logic [acpi_thc_pkg::CSR_W-1:0]     csr_write_data   = '0;

   verdict_board_type board = new();
   int unsigned send_gap_max  = 17;
   int unsigned rsp_stall_max = 17;
   int          table_items   = 0;
   int          settings_run  = 0;

   acpi_table_header_checker dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_first_byte    (req_first_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_bytes_checked (rsp_bytes_checked),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] checksum_byte(byte_list_type t, int upto);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < upto; i++) acc += t[i];
      return -acc;
   endfunction

   task automatic send_req(input logic [7:0] b, input logic first);
      int unsigned gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_first_byte <= first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (board.note_request(b, first)) table_items++;
   endtask

   task automatic send_bytes(input byte_list_type t, input int unsigned n);
      for (int i = 0; i < n; i++) send_req(t[i], i == 0);
   endtask

   // Hold off requests until every verdict is back, then let the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_cfg(input logic m, input logic [31:0] s, input logic [7:0] r);
      csr_write_enable <= 1'b1;
      csr_index        <= acpi_thc_pkg::CSR_TABLE_MODE;
      csr_write_data   <= {31'd0, m};
      @(posedge clock);
      csr_index      <= acpi_thc_pkg::CSR_HEADER_SIGNATURE;
      csr_write_data <= s;
      @(posedge clock);
      csr_index      <= acpi_thc_pkg::CSR_REQUIRED_REVISION;
      csr_write_data <= {24'd0, r};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.mode = m;
      board.sig  = s;
      board.rev  = r;
      settings_run++;
   endtask

   // Build a mostly well-formed table for the current mode, sometimes broken.
   task automatic send_table(input bit cut_short);
      byte_list_type t;
      int unsigned   n;
      int unsigned   tlen;
      int unsigned   k;
      logic [7:0]    flip;
      bit            zero_seen;
      flip = 8'($urandom_range(1, 255));
      if (!board.mode) begin
         n = acpi_thc_pkg::ROOT_LEN;
         for (int i = 0; i < n; i++) t.push_back(8'($urandom));
         for (int i = 0; i < 8; i++) t[i] = acpi_thc_pkg::ROOT_SIG[i];
         t[acpi_thc_pkg::REV_OFFSET] = board.rev;
         t[acpi_thc_pkg::SHORT_LEN-1] = checksum_byte(t, int'(acpi_thc_pkg::SHORT_LEN) - 1);
         t[acpi_thc_pkg::ROOT_LEN-1]  = checksum_byte(t, int'(acpi_thc_pkg::ROOT_LEN) - 1);
         case ($urandom_range(0, 9))
            0: begin k = $urandom_range(0, 7);   t[k] ^= flip; end
            1: t[acpi_thc_pkg::REV_OFFSET] ^= flip;
            2: begin k = $urandom_range(16, 19); t[k] ^= flip; end
            3: begin k = $urandom_range(20, 35); t[k] ^= flip; end
            default: ;
         endcase
      end else begin
         k = $urandom_range(0, 19);
         if (k == 0)     tlen = $urandom_range(0, 7);
         else if (k < 3) tlen = $urandom_range(41, 160);
         else            tlen = $urandom_range(8, 40);
         n = (tlen < acpi_thc_pkg::HDR_MIN) ? acpi_thc_pkg::HDR_MIN : tlen;
         for (int i = 0; i < n; i++) t.push_back(8'($urandom));
         zero_seen = 1'b0;
         for (int i = 0; i < 4; i++) begin
            if (!zero_seen) t[i] = board.sig[8*i +: 8];
            if (board.sig[8*i +: 8] == 8'h00) zero_seen = 1'b1;
         end
         t[4] = 8'(tlen);
         t[5] = 8'(tlen >> 8);
         t[6] = 8'h00;
         t[7] = 8'h00;
         if (n > acpi_thc_pkg::HDR_MIN) t[n-1] = checksum_byte(t, n - 1);
         case ($urandom_range(0, 9))
            0: begin k = $urandom_range(0, 3); t[k] ^= flip; end
            1: if (n > acpi_thc_pkg::HDR_MIN) begin
               k = $urandom_range(8, n - 1);
               t[k] ^= flip;
            end
            default: ;
         endcase
      end
      send_bytes(t, cut_short ? $urandom_range(1, n - 1) : n);
      // Trailing bytes without a first flag must be dropped by the block.
      if (!cut_short && $urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) send_req(8'($urandom), 1'b0);
   endtask

   initial begin : rsp_side
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_verdict(rsp_status, rsp_bytes_checked);
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $error("no request or verdict moved for %0d cycles", STALL_LIMIT);
      $display("tb_acpi_table_header_checker: FAIL");
      $finish;
   end

   initial begin : stimulus
      byte_list_type tbl;
      int            phase;
      int unsigned   tables;
      logic [31:0]   rand_sig;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Header mode, signature "A" then a zero byte: the last two positions match anything.
      write_cfg(1'b1, 32'hFFFF_0041, 8'h02);
      send_req(8'h00, 1'b0);
      send_req(8'hFF, 1'b0);
      tbl = {8'h41, 8'h00};
      send_bytes(tbl, 2);
      tbl = {8'h41, 8'h00, 8'h12, 8'h34, 8'h03, 8'h00, 8'h00, 8'h00};
      send_bytes(tbl, 8);
      tbl = {8'h41, 8'h00, 8'hFF, 8'h00, 8'h09, 8'h00, 8'h00, 8'h00, 8'h00};
      tbl[8] = checksum_byte(tbl, 8);
      send_bytes(tbl, 9);
      tbl = {8'h42, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00};
      send_bytes(tbl, 8);
      drain();

      phase = 0;
      while (table_items < ITEM_TARGET || board.verdicts < VERDICT_TARGET) begin
         rand_sig = $urandom;
         case (phase)
            0: write_cfg(1'b0, acpi_thc_pkg::RESET_HEADER_SIGNATURE,
                         acpi_thc_pkg::RESET_REQUIRED_REVISION);
            1: write_cfg(1'b1, acpi_thc_pkg::RESET_HEADER_SIGNATURE, 8'h02);
            2: write_cfg(1'b0, rand_sig, 8'h00);
            3: write_cfg(1'b1, 32'h0000_0000, 8'hFF);
            4: write_cfg(1'b0, 32'hFFFF_FFFF, 8'hFF);
            5: write_cfg(1'b1, 32'hFFFF_FFFF, 8'($urandom));
            6: begin
               rand_sig[15:8] = 8'h00;
               write_cfg(1'b1, rand_sig, 8'($urandom));
            end
            default: begin
               if ($urandom_range(0, 2) == 0)
                  rand_sig[8*$urandom_range(0, 3) +: 8] = 8'h00;
               write_cfg(1'($urandom_range(0, 1)), rand_sig, 8'($urandom));
            end
         endcase
         send_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 17;
         rsp_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
         tables = $urandom_range(3, 8);
         // Never end a phase mid-table: the last table always runs to its verdict.
         for (int i = 0; i < tables; i++)
            send_table(i < tables - 1 && $urandom_range(0, 7) == 0);
         drain();
         phase++;
      end

      $display("Checked %0d verdicts over %0d table bytes and %0d register settings.",
               board.verdicts, table_items, settings_run);
      $display("Verdicts: ok %0d, signature %0d, revision %0d, short sum %0d, %s %0d, %s %0d",
               board.status_seen[0], board.status_seen[1], board.status_seen[2],
               board.status_seen[3], "full sum", board.status_seen[4],
               "short length", board.status_seen[5]);
      if (board.errors == 0 && board.pending() == 0)
         $display("tb_acpi_table_header_checker: PASS");
      else
         $display("tb_acpi_table_header_checker: FAIL");
      $finish;
   end

endmodule

>>> sim.f
+incdir+sv
sv/acpi_thc_pkg.sv
sv/acpi_thc_csr.sv
sv/acpi_thc_core.sv
sv/acpi_thc_outq.sv
sv/acpi_table_header_checker.sv
tb/tb_acpi_table_header_checker.sv
